@@ hdl/mpdl_pkg.sv @@
// ----------------------------------------------------------------------------
// mpdl_pkg
// Shared types and constants for the mains period deviation logger.
// ----------------------------------------------------------------------------
package mpdl_pkg;

	// configuration register indexes
	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_OFFSET  = 1'b1;

	localparam int CFG_W = 21;

	// item kinds
	localparam logic KIND_CAPTURE = 1'b0;
	localparam logic KIND_STORE   = 1'b1;

	// shared divider geometry
	localparam int DIV_NW = 23;   // dividend / quotient bits
	localparam int DIV_DW = 16;   // divisor bits
	localparam int DIV_CW = 5;    // step counter bits

	localparam logic [DIV_DW-1:0] SCALE_DIVISOR  = 16'd125;
	localparam logic [31:0]       STORE_MIN_SECS = 32'd3;

	localparam int HIST_W = 18;

	typedef struct packed {
		logic        kind;
		logic [20:0] count_value;
		logic [31:0] uptime_seconds;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         slot_index;
		logic signed [15:0] average_dev;
		logic               disturbance_seen;
		logic               missing_seen;
		logic               history_shifted;
		logic [31:0]        stored_seconds;
	} out_item_t;

endpackage

@@ hdl/mpdl_div.sv @@
// ----------------------------------------------------------------------------
// mpdl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpdl_div
	import mpdl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] step_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] div_q;
	logic [DIV_DW:0]   rem_sh;
	logic              fits;

	assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_DW'(rem_sh - {1'b0, div_q});
			end else begin
				rem_q <= rem_sh[DIV_DW-1:0];
			end
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/mains_period_deviation_logger_core.sv @@
// ----------------------------------------------------------------------------
// mains_period_deviation_logger_core
// Per-cycle mains period deviation accumulator with a one-second history log.
// ----------------------------------------------------------------------------
// Input requests carry either a period capture (kind 0) or a store tick
// (kind 1). A capture is scaled to microseconds, ((count - offset) * 2) / 125,
// classified against the timeout and folded into the accumulators. A store
// reads and clears the accumulators and, from uptime 3 s on, logs one entry
// and issues one output request carrying the average and status flags.
// Both channels use valid/stall; in_stall is high whenever a request is in
// progress, so one request is handled at a time.
// The shared divider produces one quotient bit per cycle; a capture runs
// through ST_DIV, a logging store through ST_DIV and then ST_EMIT, which
// loads the output register. An early store (uptime below 3) and a store with
// no good waves skip the divider; the former is finished within ST_IDLE.
// A finished result sits in the output register; captures keep being taken
// while it waits, and only the next logging store holds off until the
// receiver drops out_stall.
// Reset clears accumulators, history pointers and returns the registers to
// timeout 100 us and offset 12500 ticks. History RAM contents are not reset.
// History is kept as a ring: once full, the head advances instead of moving
// entries, which gives the same logical shift-down.
// Configuration writes land at once and are expected only while idle.
// ----------------------------------------------------------------------------
module mains_period_deviation_logger_core
	import mpdl_pkg::*;
#(
	parameter int HISTORY_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);

	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

	state_t state_q;

	// configuration
	logic [7:0]  timeout_q;
	logic [20:0] offset_q;

	// accumulators
	logic [15:0] dev_sum_q;
	logic [15:0] good_cnt_q;
	logic [15:0] dist_cnt_q;
	logic [15:0] miss_cnt_q;

	// request in flight
	logic        kind_q;
	logic        neg_q;
	logic        dis_q;
	logic        mis_q;
	logic [31:0] secs_q;
	logic [15:0] avg_q;

	// history pointers
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] head_q;
	logic             full_q;
	logic [HIST_W-1:0] hist_mem [HISTORY_DEPTH];

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	logic in_acc;
	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// capture scaling: magnitude of 2*(count - offset)
	logic signed [21:0] diff;
	logic signed [22:0] diff2;
	logic [DIV_NW-1:0]  cap_mag;
	logic               cap_neg;
	assign diff    = $signed({1'b0, in_data.count_value}) - $signed({1'b0, offset_q});
	assign diff2   = {diff, 1'b0};
	assign cap_neg = diff2[22];
	assign cap_mag = cap_neg ? DIV_NW'(-diff2) : DIV_NW'(diff2);

	// store average: magnitude of the signed sum
	logic signed [16:0] sum_ext;
	logic [16:0]        sum_mag;
	assign sum_ext = {dev_sum_q[15], dev_sum_q};
	assign sum_mag = dev_sum_q[15] ? 17'(-sum_ext) : 17'(sum_ext);

	logic store_logs;
	assign store_logs = (in_data.uptime_seconds >= STORE_MIN_SECS);

	// shared divider
	logic              div_start;
	logic [DIV_NW-1:0] div_dividend;
	logic [DIV_DW-1:0] div_divisor;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = cap_mag;
		div_divisor  = SCALE_DIVISOR;
		if (in_acc) begin
			if (in_data.kind == KIND_CAPTURE) begin
				div_start = 1'b1;
			end else begin
				div_start    = store_logs && (good_cnt_q != '0);
				div_dividend = DIV_NW'(sum_mag);
				div_divisor  = good_cnt_q;
			end
		end
	end

	mpdl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// signed deviation and classification at divider completion
	logic signed [16:0] dev;
	logic signed [16:0] lim;
	assign dev = neg_q ? -$signed({1'b0, div_quo[15:0]}) : $signed({1'b0, div_quo[15:0]});
	assign lim = $signed({9'b0, timeout_q});

	logic emit_go;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	logic [IDX_W-1:0] phys_addr;
	assign phys_addr = full_q ? head_q : wr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			timeout_q   <= 8'd100;
			offset_q    <= 21'd12500;
			dev_sum_q   <= '0;
			good_cnt_q  <= '0;
			dist_cnt_q  <= '0;
			miss_cnt_q  <= '0;
			wr_idx_q    <= '0;
			head_q      <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMEOUT: timeout_q <= cfg_data[7:0];
					CFG_OFFSET:  offset_q  <= cfg_data[20:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_data.kind == KIND_CAPTURE) begin
							state_q <= ST_DIV;
						end else begin
							dev_sum_q  <= '0;
							good_cnt_q <= '0;
							dist_cnt_q <= '0;
							miss_cnt_q <= '0;
							if (store_logs) begin
								state_q <= (good_cnt_q != '0) ? ST_DIV : ST_EMIT;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (kind_q == KIND_CAPTURE) begin
							state_q <= ST_IDLE;
							if (dev > lim) begin
								dist_cnt_q <= dist_cnt_q + 1'b1;
							end else if (dev < -lim) begin
								miss_cnt_q <= miss_cnt_q + 1'b1;
							end else begin
								dev_sum_q  <= dev_sum_q + dev[15:0];
								good_cnt_q <= good_cnt_q + 1'b1;
							end
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						if (full_q) begin
							head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
						end else if (wr_idx_q == LAST_IDX) begin
							full_q <= 1'b1;
						end else begin
							wr_idx_q <= wr_idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload and output register (no reset needed)
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= in_data.kind;
			secs_q <= in_data.uptime_seconds;
			dis_q  <= (dist_cnt_q != '0);
			mis_q  <= (miss_cnt_q != '0);
			avg_q  <= '0;
			neg_q  <= (in_data.kind == KIND_CAPTURE) ? cap_neg : dev_sum_q[15];
		end
		if (state_q == ST_DIV && div_done && kind_q == KIND_STORE) begin
			avg_q <= neg_q ? 16'(-div_quo[15:0]) : div_quo[15:0];
		end
		if (emit_go) begin
			out_q.slot_index       <= 8'(wr_idx_q);
			out_q.average_dev      <= $signed(avg_q);
			out_q.disturbance_seen <= dis_q;
			out_q.missing_seen     <= mis_q;
			out_q.history_shifted  <= full_q;
			out_q.stored_seconds   <= secs_q;
		end
	end

	// history RAM
	always_ff @(posedge clk) begin
		if (emit_go) begin
			hist_mem[phys_addr] <= {mis_q, dis_q, avg_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ring pointers: head only moves once the history has filled
	a_head_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!full_q |-> head_q == '0)
		else $error("history head moved before history filled");

	a_full_idx: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> wr_idx_q == LAST_IDX)
		else $error("write index not at last slot while full");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider completed outside divide state");

	a_store_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_data.kind == KIND_STORE) |=>
			(dev_sum_q == '0 && good_cnt_q == '0 && dist_cnt_q == '0 && miss_cnt_q == '0))
		else $error("accumulators not cleared by store");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mains period deviation logger core.
// ----------------------------------------------------------------------------
// A cycle-free predictor folds every accepted capture request into its own
// accumulators and, on each logging store, queues the history entry it
// expects. The output monitor compares each accepted entry field by field
// with the oldest queued one. Both handshakes idle at random, the receiver
// holds off for long stretches, and the register settings change between
// phases while the core is idle.
// ----------------------------------------------------------------------------
module tb
	import mpdl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HISTORY_DEPTH  = 256;
	localparam int RESET_TIMEOUT  = 100;
	localparam int RESET_OFFSET   = 12500;
	localparam int RANDOM_ITEMS   = 900;
	localparam int PHASE_ITEMS    = 150;
	localparam int MIN_LOGGED     = 300;   // enough to fill the history and shift it
	localparam int SETTLE_CYCLES  = 40;    // enough for a capture or a store to finish
	localparam int LONG_HOLD      = 300;
	localparam int QUIET_LIMIT    = 2000;  // long hold + store + gap + settle, with margin
	localparam int PLAN_LEN       = 5;

	// register settings of the first phases; later phases draw their own
	localparam logic [7:0]  TIMEOUT_PLAN [PLAN_LEN] = '{8'd100, 8'd0, 8'd255, 8'd200, 8'd255};
	localparam logic [20:0] OFFSET_PLAN  [PLAN_LEN] =
		'{21'd12500, 21'd0, 21'h1FFFFF, 21'd1262500, 21'd12500};

	// ------------------------------------------------------------------------
	// predictor of the logged history entries
	// ------------------------------------------------------------------------
	class deviation_log_predictor;
		logic [7:0]  timeout_us;
		logic [20:0] offset_ticks;
		logic [15:0] dev_sum;
		logic [15:0] good_waves;
		logic [15:0] disturb_waves;
		logic [15:0] missing_waves;
		logic [7:0]  write_slot;
		bit          history_full;
		out_item_t   pending_entries[$];
		int unsigned errors, captures, stores, logged, early, shifted, dis_flags, mis_flags;

		function new();
			timeout_us    = RESET_TIMEOUT;
			offset_ticks  = RESET_OFFSET;
			dev_sum       = '0;
			good_waves    = '0;
			disturb_waves = '0;
			missing_waves = '0;
			write_slot    = '0;
			history_full  = 1'b0;
			errors        = 0;
			captures      = 0;
			stores        = 0;
			logged        = 0;
			early         = 0;
			shifted       = 0;
			dis_flags     = 0;
			mis_flags     = 0;
		endfunction

		// fold one accepted request into the accumulators / history
		function void take_request(in_item_t req);
			longint    diff, dev, lim;
			int        avg;
			out_item_t entry;
			if (req.kind == KIND_CAPTURE) begin
				captures++;
				diff = longint'(req.count_value) - longint'(offset_ticks);
				dev  = (diff * 2) / 125;    // truncates toward zero
				lim  = longint'(timeout_us);
				if (dev > lim)
					disturb_waves++;
				else if (dev < -lim)
					missing_waves++;
				else begin
					dev_sum += dev[15:0];
					good_waves++;
				end
			end else begin
				stores++;
				if (req.uptime_seconds < STORE_MIN_SECS) begin
					early++;
				end else begin
					avg = (good_waves != 0) ? int'($signed(dev_sum)) / int'(good_waves) : 0;
					entry.slot_index       = write_slot;
					entry.average_dev      = avg[15:0];
					entry.disturbance_seen = (disturb_waves != 0);
					entry.missing_seen     = (missing_waves != 0);
					entry.history_shifted  = history_full;
					entry.stored_seconds   = req.uptime_seconds;
					pending_entries.push_back(entry);
					logged++;
					shifted   += history_full;
					dis_flags += entry.disturbance_seen;
					mis_flags += entry.missing_seen;
					if (write_slot < HISTORY_DEPTH - 1)
						write_slot++;
					else
						history_full = 1'b1;
				end
				// a store always clears, logging or not
				dev_sum       = '0;
				good_waves    = '0;
				disturb_waves = '0;
				missing_waves = '0;
			end
		endfunction

		function void compare_field(string field, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_entry(out_item_t got);
			out_item_t want;
			if (pending_entries.size() == 0) begin
				$error("unexpected history entry for slot %0d", got.slot_index);
				errors++;
				return;
			end
			want = pending_entries.pop_front();
			compare_field("slot_index", want.slot_index, got.slot_index);
			compare_field("average_dev", want.average_dev, got.average_dev);
			compare_field("disturbance_seen", want.disturbance_seen, got.disturbance_seen);
			compare_field("missing_seen", want.missing_seen, got.missing_seen);
			compare_field("history_shifted", want.history_shifted, got.history_shifted);
			compare_field("stored_seconds", want.stored_seconds, got.stored_seconds);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_data;

	deviation_log_predictor predictor;

	int unsigned random_items = 0;
	int unsigned phase_items  = 0;
	int unsigned settings     = 1;   // reset values count as the first setting
	int unsigned calm_left    = 0;
	bit          calm_tx      = 1'b0;
	int unsigned quiet_cycles = 0;

	mains_period_deviation_logger_core #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// request builders - unused fields carry random bits so every bit toggles
	// ------------------------------------------------------------------------
	function automatic in_item_t capture_req(input logic [20:0] ticks);
		in_item_t req;
		req.kind           = KIND_CAPTURE;
		req.count_value    = ticks;
		req.uptime_seconds = $urandom;
		return req;
	endfunction

	function automatic in_item_t store_req(input logic [31:0] secs);
		in_item_t req;
		req.kind           = KIND_STORE;
		req.count_value    = 21'($urandom);
		req.uptime_seconds = secs;
		return req;
	endfunction

	// counter value giving roughly the wanted deviation (us) at the current offset
	function automatic logic [20:0] count_for(input longint dev);
		longint ticks;
		ticks = longint'(predictor.offset_ticks) + (dev * 125) / 2
			+ longint'($urandom_range(0, 40)) - 20;
		if (ticks < 0)
			ticks = 0;
		if (ticks > 64'h1FFFFF)
			ticks = 64'h1FFFFF;
		return ticks[20:0];
	endfunction

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------
	// Offers one request after a random gap and returns at the edge that takes
	// it. Gapless stretches come and go so back-to-back requests are exercised.
	task automatic send_request(input in_item_t req);
		int unsigned gap;
		if (calm_left == 0) begin
			calm_tx   = ($urandom_range(0, 3) == 0);
			calm_left = $urandom_range(20, 60);
		end
		calm_left--;
		gap = calm_tx ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predictor.take_request(req);
	endtask

	// drop valid and wait until every queued entry has come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predictor.pending_entries.size() != 0)
			@(posedge clk);
	endtask

	// Register writes only while idle: a capture in flight has no result to
	// wait for, so settle for its full latency after the queue empties.
	task automatic program_registers(input logic [7:0] timeout, input logic [20:0] offset);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_data  <= CFG_W'(timeout);
		@(negedge clk);
		cfg_index <= CFG_OFFSET;
		cfg_data  <= offset;
		@(negedge clk);
		cfg_we    <= 1'b0;
		predictor.timeout_us   = timeout;
		predictor.offset_ticks = offset;
		settings++;
	endtask

	// One mains second: a few captures around the nominal period, then a
	// store. A burst is a long one-signed run near the timeout, which can drive
	// the 16-bit sum through its wrap. Now and then the store is left out.
	task automatic run_second(input bit burst);
		int unsigned n, r;
		int          lim;
		longint      sgn, dev;
		logic [31:0] secs;
		lim = int'(predictor.timeout_us);
		sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
		n   = burst ? $urandom_range(140, 180) : $urandom_range(0, 4);
		repeat (n) begin
			if (!burst && $urandom_range(0, 9) == 0) begin
				send_request(capture_req(21'($urandom)));
			end else begin
				if (burst)
					dev = sgn * longint'($urandom_range(lim * 3 / 4, lim));
				else
					dev = longint'($urandom_range(0, 2 * lim + 40)) - longint'(lim + 20);
				send_request(capture_req(count_for(dev)));
			end
			phase_items++;
			random_items++;
		end
		r = $urandom_range(0, 99);
		if (r < 5)
			return;
		if (r < 13)
			secs = $urandom_range(0, 2);
		else if (r < 17)
			secs = STORE_MIN_SECS;
		else if (r < 20)
			secs = '1;
		else
			secs = $urandom;
		send_request(store_req(secs));
		phase_items++;
		random_items++;
	endtask

	// ------------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------------
	// Per entry a random hold-off; a gapless stretch of 40 in every 120 entries,
	// and now and then a long hold so captures pile up and the next store stalls.
	initial begin : receiver
		int unsigned hold, taken;
		taken     = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 150 == 75)
				hold = LONG_HOLD;
			else if ((taken / 40) % 3 == 2)
				hold = 0;
			else
				hold = $urandom_range(0, 17);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			taken++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			predictor.check_entry(out_data);
	end

	// watchdog: cycles in which neither side moves a request
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned phase;
		bit          paused;
		logic [7:0]  timeout;
		logic [20:0] offset;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_TIMEOUT;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		predictor = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, at reset settings (timeout 100 us, offset 12500 ticks)
		send_request(store_req(32'd0));                  // early store, nothing logged
		send_request(store_req(32'd3));                  // first logging store, no good waves
		send_request(capture_req(RESET_OFFSET));         // 0 us
		send_request(capture_req(RESET_OFFSET + 63));    // +1 us
		send_request(capture_req(RESET_OFFSET - 63));    // -1 us, truncation toward zero
		send_request(capture_req(RESET_OFFSET - 62));    // rounds to 0 us
		send_request(capture_req(RESET_OFFSET + 6250));  // exactly +timeout: still good
		send_request(capture_req(RESET_OFFSET - 6250));  // exactly -timeout: still good
		send_request(store_req(32'd2));                  // early store clears the lot
		send_request(capture_req(RESET_OFFSET + 6313));  // +101 us: disturbance
		send_request(capture_req(RESET_OFFSET - 6313));  // -101 us: missing wave
		send_request(capture_req(21'd0));                // counter floor
		send_request(capture_req(21'h1FFFFF));           // counter ceiling, far above range
		send_request(capture_req(RESET_OFFSET + 6250));
		send_request(capture_req(RESET_OFFSET + 63));
		send_request(store_req(32'hFFFF_FFFF));          // both flags, max uptime
		send_request(capture_req(RESET_OFFSET - 63));
		send_request(capture_req(RESET_OFFSET - 63));
		send_request(capture_req(RESET_OFFSET + 63));
		send_request(store_req(32'd3));                  // -1 / 3 truncates to 0
		send_request(capture_req(RESET_OFFSET - 6250));
		send_request(capture_req(RESET_OFFSET + 63));
		send_request(store_req(32'h8000_0000));          // -99 / 2 truncates to -49

		// random phases, each under its own register setting
		phase = 0;
		while (random_items < RANDOM_ITEMS || predictor.logged < MIN_LOGGED) begin
			if (phase < PLAN_LEN) begin
				timeout = TIMEOUT_PLAN[phase];
				offset  = OFFSET_PLAN[phase];
			end else begin
				timeout = $urandom_range(0, 255);
				offset  = $urandom_range(0, 21'h1FFFFF);
			end
			if (phase != 0)
				program_registers(timeout, offset);
			phase_items = 0;
			paused      = 1'b0;
			// wide timeouts get a burst straight away, which may wrap the sum
			if (timeout >= 128)
				run_second(1'b1);
			while (phase_items < PHASE_ITEMS) begin
				run_second($urandom_range(0, 99) == 0);
				if (!paused && phase_items >= PHASE_ITEMS / 2) begin
					drain();   // let the pipeline run dry mid-phase
					paused = 1'b1;
				end
			end
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run: %0d captures and %0d stores over %0d register settings",
			predictor.captures, predictor.stores, settings);
		$display("History: %0d entries logged (%0d after wrap), %0d early stores, %0d/%0d flagged",
			predictor.logged, predictor.shifted, predictor.early,
			predictor.dis_flags, predictor.mis_flags);
		if (predictor.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
